[hdl/rqfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqfs_pkg
// Types and constants shared by the ring queue with flow status.
// ----------------------------------------------------------------------------
package rqfs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ENTRY_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 6;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_FLOW_DOWN   = 3'd1,
		ST_NOT_ALLOC   = 3'd2,
		ST_WOULD_BLOCK = 3'd3,
		ST_PEER_GONE   = 3'd4
	} status_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOW_DOWN = 2'd0,
		CFG_READ_ONLY = 2'd1,
		CFG_PEER_GONE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

[hdl/rqfs_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqfs interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface rqfs_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [rqfs_pkg::ENTRY_W-1:0]  entry_in;

	modport source (output valid, output cmd, output entry_in, input ready);
	modport sink   (input valid, input cmd, input entry_in, output ready);
endinterface

interface rqfs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rqfs_pkg::STATUS_W-1:0] status;
	logic [rqfs_pkg::ENTRY_W-1:0]  entry_out;
	logic [rqfs_pkg::COUNT_W-1:0]  queued_count;

	modport source (output valid, output status, output entry_out, output queued_count,
		input ready);
	modport sink   (input valid, input status, input entry_out, input queued_count,
		output ready);
endinterface

interface rqfs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rqfs_pkg::CFG_IDX_W-1:0] index;
	logic                           data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/rqfs_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqfs_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rqfs_mem #(
	parameter int DEPTH = rqfs_pkg::DEPTH_DEF,
	parameter int PW    = $clog2(DEPTH)
) (
	input  wire                            clk,
	input  wire  rqfs_pkg::mem_ctl_t       ctl,
	input  wire  [PW-1:0]                  wr_addr,
	input  wire  [rqfs_pkg::ENTRY_W-1:0]   wr_data,
	input  wire  [PW-1:0]                  rd_addr,
	output logic [rqfs_pkg::ENTRY_W-1:0]   rd_data
);
	import rqfs_pkg::*;

	logic [ENTRY_W-1:0] slots [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			slots[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= slots[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/rqfs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqfs_ctrl
// Pointers, flow registers, status decision and the result register.
// ----------------------------------------------------------------------------
module rqfs_ctrl #(
	parameter int DEPTH = rqfs_pkg::DEPTH_DEF,
	parameter int PW    = $clog2(DEPTH)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	rqfs_req_if.sink                     req,
	rqfs_rsp_if.source                   rsp,
	rqfs_cfg_if.sink                     cfg,
	output rqfs_pkg::mem_ctl_t           mem_ctl,
	output logic [PW-1:0]                head_addr,
	output logic [PW-1:0]                tail_addr,
	input  wire  [rqfs_pkg::ENTRY_W-1:0] rd_data
);
	import rqfs_pkg::*;

	localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [PW-1:0] head_q, tail_q, cnt_q;
	logic          flow_down_q, read_only_q, peer_gone_q;
	logic          rsp_valid_s1, rd_ok_s1;
	status_t       status_s1;
	logic [PW-1:0] cnt_s1;
	logic          take, full, empty, wr_ok, rd_ok;
	status_t       status_d;
	logic [PW-1:0] cnt_d;
	logic [CW-1:0] cnt_ext;

	assign take      = req.valid && req.ready;
	assign req.ready = !rsp_valid_s1 || rsp.ready;
	assign cfg.ready = 1'b1;

	assign full  = (cnt_q == LAST);
	assign empty = (head_q == tail_q);

	always_comb begin
		status_d = ST_OK;
		wr_ok    = 1'b0;
		rd_ok    = 1'b0;
		if (req.cmd == CMD_WRITE) begin
			if (flow_down_q) begin
				status_d = ST_FLOW_DOWN;
			end else if (read_only_q) begin
				status_d = ST_NOT_ALLOC;
			end else if (full) begin
				status_d = ST_WOULD_BLOCK;
			end else begin
				wr_ok = 1'b1;
			end
		end else begin
			if (!empty) begin
				rd_ok = 1'b1;
			end else if (flow_down_q) begin
				status_d = ST_FLOW_DOWN;
			end else if (peer_gone_q) begin
				status_d = ST_PEER_GONE;
			end else begin
				status_d = ST_WOULD_BLOCK;
			end
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (wr_ok) begin
			cnt_d = cnt_q + PW'(1);
		end else if (rd_ok) begin
			cnt_d = cnt_q - PW'(1);
		end
	end

	assign mem_ctl.wr_en = take && wr_ok;
	assign mem_ctl.rd_en = take && rd_ok;
	assign head_addr     = head_q;
	assign tail_addr     = tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			if (wr_ok) begin
				head_q <= (head_q == LAST) ? '0 : head_q + PW'(1);
			end
			if (rd_ok) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + PW'(1);
			end
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_down_q <= 1'b0;
			read_only_q <= 1'b0;
			peer_gone_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FLOW_DOWN: flow_down_q <= cfg.data;
				CFG_READ_ONLY: read_only_q <= cfg.data;
				CFG_PEER_GONE: peer_gone_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s1 <= status_d;
			rd_ok_s1  <= rd_ok;
			cnt_s1    <= cnt_d;
		end
	end

	assign cnt_ext          = CW'(cnt_s1);
	assign rsp.valid        = rsp_valid_s1;
	assign rsp.status       = status_s1;
	assign rsp.entry_out    = rd_ok_s1 ? rd_data : '0;
	assign rsp.queued_count = cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

[hdl/ring_queue_with_flow_status_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ring_queue_with_flow_status_unit
// Circular queue of buffer indices with flow, allocation and peer status.
// ----------------------------------------------------------------------------
// channel  dir  payload                              transfer
// req      in   cmd, entry_in                        valid && ready
// rsp      out  status, entry_out, queued_count      valid && ready
// cfg      in   index, data                          valid && ready
//
// one request per cycle while req.ready is high; each result appears in the cycle after its transfer
// the slot memory read port is registered and holds its data while a result waits
// req.ready drops only while a result waits and rsp.ready is low
// cfg is always ready; reset clears pointers and flow registers
// ----------------------------------------------------------------------------
module ring_queue_with_flow_status_unit #(
	parameter int DEPTH = rqfs_pkg::DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	rqfs_req_if.sink    req,
	rqfs_rsp_if.source  rsp,
	rqfs_cfg_if.sink    cfg
);
	import rqfs_pkg::*;

	localparam int PW = $clog2(DEPTH);

	mem_ctl_t           mem_ctl;
	logic [PW-1:0]      head_addr, tail_addr;
	logic [ENTRY_W-1:0] rd_data;

	rqfs_ctrl #(
		.DEPTH (DEPTH),
		.PW    (PW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mem_ctl   (mem_ctl),
		.head_addr (head_addr),
		.tail_addr (tail_addr),
		.rd_data   (rd_data)
	);

	rqfs_mem #(
		.DEPTH (DEPTH),
		.PW    (PW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (head_addr),
		.wr_data (req.entry_in),
		.rd_addr (tail_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
